[rtl/shortest_path_engine_assert.svh]
// Assertion macros for the shortest path engine.
`ifndef SHORTEST_PATH_ENGINE_ASSERT_SVH
`define SHORTEST_PATH_ENGINE_ASSERT_SVH
`ifndef SYNTH
`define SPE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);
`define SPE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);
`else
`define SPE_ASSERT_IMP(lbl, ante, cons, msg)
`define SPE_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/spe_pkg.sv]
package spe_pkg;

	localparam logic [1:0] CMD_ADD   = 2'd0;
	localparam logic [1:0] CMD_QUERY = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [25:0] DIST_MAX = 26'h3FFFFFF;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_SCAN,
		ST_VISIT,
		ST_EDGE_RD,
		ST_EDGE_CHK,
		ST_RELAX,
		ST_FIN,
		ST_FIN_WAIT
	} state_t;

	typedef struct packed {
		logic add_edge;
		logic clr_store;
		logic q_start;
		logic init_src;
		logic scan_clr;
		logic scan_step;
		logic visit;
		logic edge_rd;
		logic edge_chk;
		logic relax;
		logic fin_rd;
		logic res_load;
	} ctrl_t;

	typedef struct packed {
		logic in_range;
		logic scan_end;
		logic best_valid;
		logic edge_end;
		logic out_free;
	} stat_t;

endpackage

[rtl/spe_ram.sv]
module spe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/spe_ctrl.sv]
`include "shortest_path_engine_assert.svh"
module spe_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	input  logic [1:0]     s_tuser,
	output logic           s_tready,
	input  spe_pkg::stat_t stat,
	output spe_pkg::ctrl_t ctrl
);

	spe_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spe_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			spe_pkg::ST_IDLE: begin
				if (s_tvalid && s_tuser == spe_pkg::CMD_QUERY) begin
					state_d = stat.in_range ? spe_pkg::ST_INIT : spe_pkg::ST_FIN;
				end
			end
			spe_pkg::ST_INIT:     state_d = spe_pkg::ST_SCAN;
			spe_pkg::ST_SCAN: begin
				if (stat.scan_end) begin
					state_d = stat.best_valid ? spe_pkg::ST_VISIT : spe_pkg::ST_FIN;
				end
			end
			spe_pkg::ST_VISIT:    state_d = spe_pkg::ST_EDGE_RD;
			spe_pkg::ST_EDGE_RD: begin
				state_d = stat.edge_end ? spe_pkg::ST_SCAN : spe_pkg::ST_EDGE_CHK;
			end
			spe_pkg::ST_EDGE_CHK: state_d = spe_pkg::ST_RELAX;
			spe_pkg::ST_RELAX:    state_d = spe_pkg::ST_EDGE_RD;
			spe_pkg::ST_FIN:      state_d = spe_pkg::ST_FIN_WAIT;
			spe_pkg::ST_FIN_WAIT: begin
				if (stat.out_free) begin
					state_d = spe_pkg::ST_IDLE;
				end
			end
			default:              state_d = spe_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		s_tready = 1'b0;
		unique case (state_q)
			spe_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					unique case (s_tuser)
						spe_pkg::CMD_ADD:   ctrl.add_edge = 1'b1;
						spe_pkg::CMD_QUERY: ctrl.q_start = 1'b1;
						spe_pkg::CMD_CLEAR: ctrl.clr_store = 1'b1;
						default: ;
					endcase
				end
			end
			spe_pkg::ST_INIT: begin
				ctrl.init_src = 1'b1;
				ctrl.scan_clr = 1'b1;
			end
			spe_pkg::ST_SCAN:     ctrl.scan_step = 1'b1;
			spe_pkg::ST_VISIT:    ctrl.visit = 1'b1;
			spe_pkg::ST_EDGE_RD: begin
				if (stat.edge_end) begin
					ctrl.scan_clr = 1'b1;
				end else begin
					ctrl.edge_rd = 1'b1;
				end
			end
			spe_pkg::ST_EDGE_CHK: ctrl.edge_chk = 1'b1;
			spe_pkg::ST_RELAX:    ctrl.relax = 1'b1;
			spe_pkg::ST_FIN:      ctrl.fin_rd = 1'b1;
			spe_pkg::ST_FIN_WAIT: ctrl.res_load = stat.out_free;
			default: ;
		endcase
	end

	`SPE_ASSERT_IMP(a_load_free, ctrl.res_load, stat.out_free, "result loaded over a pending one")
	`SPE_ASSERT_NXT(a_start_leaves_idle, ctrl.q_start, state_q != spe_pkg::ST_IDLE, "query did not start")
	`SPE_ASSERT_IMP(a_no_accept_busy, state_q != spe_pkg::ST_IDLE, !s_tready, "item taken while busy")

endmodule

[rtl/spe_datapath.sv]
`include "shortest_path_engine_assert.svh"
module spe_datapath #(
	parameter int MAX_NODES   = 256,
	parameter int MAX_EDGES   = 1024,
	parameter int WEIGHT_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [8:0]     node_count,
	input  logic [47:0]    s_tdata,
	input  spe_pkg::ctrl_t ctrl,
	output spe_pkg::stat_t stat,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [31:0]    m_tdata,
	output logic [1:0]     m_tuser
);

	localparam int NB  = $clog2(MAX_NODES);
	localparam int NCW = $clog2(MAX_NODES + 1);
	localparam int LW  = (NCW > 9) ? NCW : 9;
	localparam int EFW = $clog2(MAX_EDGES + 1);
	localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int EW  = 2 * NB + WEIGHT_BITS;
	localparam int DW  = WEIGHT_BITS + NB + 1;
	localparam int SW  = (DW > 26) ? DW : 26;

	logic [LW-1:0] n_eff;
	logic [LW-1:0] in_src, in_dst, in_qs, in_qd;
	assign n_eff = (LW'(node_count) < LW'(MAX_NODES)) ? LW'(node_count) : LW'(MAX_NODES);
	assign in_src = LW'(s_tdata[7:0]);
	assign in_dst = LW'(s_tdata[15:8]);
	assign in_qs  = LW'(s_tdata[39:32]);
	assign in_qd  = LW'(s_tdata[47:40]);

	logic [EFW-1:0] edge_fill_q;
	logic           drop_q;
	logic           add_ok;
	assign add_ok = (edge_fill_q < EFW'(MAX_EDGES)) && (in_src < n_eff) && (in_dst < n_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_fill_q <= '0;
			drop_q <= 1'b0;
		end else if (ctrl.clr_store) begin
			edge_fill_q <= '0;
			drop_q <= 1'b0;
		end else if (ctrl.add_edge) begin
			if (add_ok) begin
				edge_fill_q <= edge_fill_q + 1'b1;
			end else begin
				drop_q <= 1'b1;
			end
		end
	end

	logic [EFW-1:0] e_q;
	logic [EW-1:0]  edge_rdata;
	logic [EW-1:0]  edge_wdata;
	assign edge_wdata = {WEIGHT_BITS'(s_tdata[31:16]), NB'(s_tdata[15:8]), NB'(s_tdata[7:0])};

	spe_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_ram (
		.clk   (clk),
		.we    (ctrl.add_edge && add_ok),
		.waddr (edge_fill_q[EAW-1:0]),
		.wdata (edge_wdata),
		.re    (ctrl.edge_rd),
		.raddr (e_q[EAW-1:0]),
		.rdata (edge_rdata)
	);

	logic [NB-1:0]  qs_q, qd_q, u_q, best_n_q, k_s1, eg_src_q, eg_dst_q;
	logic [DW-1:0]  du_q, best_d_q;
	logic [WEIGHT_BITS-1:0] eg_w_q;
	logic [NCW-1:0] k_q;
	logic           v_s1, best_v_q;
	logic [MAX_NODES-1:0] visited_q, dvalid_q;

	logic           dist_we, dist_re;
	logic [NB-1:0]  dist_waddr, dist_raddr;
	logic [DW-1:0]  dist_wdata, dist_rdata, nd;
	logic           k_live, cand, relevant, better;

	assign k_live   = k_q < NCW'(MAX_NODES);
	assign nd       = du_q + DW'(eg_w_q);
	assign relevant = (eg_src_q == u_q) && (LW'(eg_dst_q) < n_eff);
	assign better   = !dvalid_q[eg_dst_q] || (nd < dist_rdata);
	assign cand     = v_s1 && (LW'(k_s1) < n_eff) && dvalid_q[k_s1] && !visited_q[k_s1];

	always_comb begin
		dist_we = 1'b0;
		dist_waddr = qs_q;
		dist_wdata = '0;
		if (ctrl.relax) begin
			dist_we = relevant && better;
			dist_waddr = eg_dst_q;
			dist_wdata = nd;
		end else if (ctrl.init_src) begin
			dist_we = 1'b1;
		end
		dist_re = 1'b0;
		dist_raddr = qd_q;
		if (ctrl.scan_step) begin
			dist_re = k_live;
			dist_raddr = k_q[NB-1:0];
		end else if (ctrl.edge_chk) begin
			dist_re = 1'b1;
			dist_raddr = edge_rdata[2*NB-1:NB];
		end else if (ctrl.fin_rd) begin
			dist_re = 1'b1;
		end
	end

	spe_ram #(.WIDTH(DW), .DEPTH(MAX_NODES)) u_dist_ram (
		.clk   (clk),
		.we    (dist_we),
		.waddr (dist_waddr),
		.wdata (dist_wdata),
		.re    (dist_re),
		.raddr (dist_raddr),
		.rdata (dist_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_q <= '0;
			dvalid_q <= '0;
			v_s1 <= 1'b0;
			best_v_q <= 1'b0;
			k_q <= '0;
			e_q <= '0;
		end else begin
			if (ctrl.q_start) begin
				visited_q <= '0;
				dvalid_q <= '0;
			end
			if (dist_we) begin
				dvalid_q[dist_waddr] <= 1'b1;
			end
			if (ctrl.visit) begin
				visited_q[best_n_q] <= 1'b1;
				e_q <= '0;
			end
			if (ctrl.edge_rd) begin
				e_q <= e_q + 1'b1;
			end
			if (ctrl.scan_clr) begin
				k_q <= '0;
				v_s1 <= 1'b0;
				best_v_q <= 1'b0;
			end else if (ctrl.scan_step) begin
				v_s1 <= k_live;
				if (k_live) begin
					k_q <= k_q + 1'b1;
				end
				if (cand && (!best_v_q || dist_rdata < best_d_q)) begin
					best_v_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.q_start) begin
			qs_q <= NB'(s_tdata[39:32]);
			qd_q <= NB'(s_tdata[47:40]);
		end
		if (ctrl.scan_step) begin
			k_s1 <= k_q[NB-1:0];
			if (cand && (!best_v_q || dist_rdata < best_d_q)) begin
				best_n_q <= k_s1;
				best_d_q <= dist_rdata;
			end
		end
		if (ctrl.visit) begin
			u_q <= best_n_q;
			du_q <= best_d_q;
		end
		if (ctrl.edge_chk) begin
			eg_src_q <= edge_rdata[NB-1:0];
			eg_dst_q <= edge_rdata[2*NB-1:NB];
			eg_w_q <= edge_rdata[EW-1:2*NB];
		end
	end

	logic          out_valid_q, out_found_q, out_drop_q;
	logic [25:0]   out_dist_q, res_dist;
	logic [SW-1:0] dx;
	logic          res_found;
	assign res_found = visited_q[qd_q];
	assign dx = SW'(dist_rdata);
	assign res_dist = !res_found ? 26'd0 : (dx > SW'(spe_pkg::DIST_MAX)) ? spe_pkg::DIST_MAX :
		26'(dx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.res_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.res_load) begin
			out_dist_q <= res_dist;
			out_found_q <= res_found;
			out_drop_q <= drop_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_dist_q};
	assign m_tuser  = {out_drop_q, out_found_q};

	assign stat.in_range   = (in_qs < n_eff) && (in_qd < n_eff);
	assign stat.scan_end   = !k_live && !v_s1;
	assign stat.best_valid = best_v_q;
	assign stat.edge_end   = e_q == edge_fill_q;
	assign stat.out_free   = !out_valid_q || m_tready;

	`SPE_ASSERT_IMP(a_visit_new, ctrl.visit, !visited_q[best_n_q], "node visited twice")
	`SPE_ASSERT_NXT(a_write_marks, dist_we, dvalid_q[$past(dist_waddr)], "distance write not marked")
	`SPE_ASSERT_IMP(a_fill_cap, ctrl.add_edge && add_ok, edge_fill_q < EFW'(MAX_EDGES),
		"edge store overrun")

endmodule

[rtl/shortest_path_engine.sv]
// Directed weighted graph engine running Dijkstra over an edge store. Add-edge
// and clear items are taken only while idle, as are queries. A query in range
// first sets up the source and scans the distance memory, then for each reached
// node makes a pass over the stored edges plus another scan of the distance
// memory, and then reads out the target, taking longer while an earlier result
// still waits at the output. The nearest unvisited node is found by a linear
// scan. An out-of-range query goes straight to the read-out of the target.
module shortest_path_engine #(
	parameter int MAX_NODES   = 256,
	parameter int MAX_EDGES   = 1024,
	parameter int WEIGHT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [8:0]  cfg_data,  // node_count
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // edge_source, edge_target, edge_weight, query_source, query_target
	input  logic [1:0]  s_tuser,   // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // path_distance
	output logic [1:0]  m_tuser    // path_found, edges_dropped
);

	logic [8:0]     node_count_q;
	spe_pkg::ctrl_t ctrl;
	spe_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= 9'd256;
		end else if (cfg_valid) begin
			node_count_q <= cfg_data;
		end
	end

	spe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	spe_datapath #(
		.MAX_NODES   (MAX_NODES),
		.MAX_EDGES   (MAX_EDGES),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.node_count (node_count_q),
		.s_tdata    (s_tdata),
		.ctrl       (ctrl),
		.stat       (stat),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule

[test/shortest_path_checker.sv]
module shortest_path_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [8:0]  cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic [1:0]  m_tuser,
	output int          fails,
	output int          pending,
	output int          results
);

	localparam int NODES = 256;
	localparam int EDGES = 1024;

	typedef struct packed {
		logic [31:0] span;
		logic [1:0]  flags;
	} route_t;

	route_t routes_due[$];
	logic [8:0]  node_count;
	logic [7:0]  e_src [EDGES];
	logic [7:0]  e_dst [EDGES];
	logic [15:0] e_wgt [EDGES];
	int          e_fill;
	logic        dropped;

	function automatic int live_nodes();
		return (node_count < NODES) ? int'(node_count) : NODES;
	endfunction

	function automatic route_t solve_route(input int s, input int d);
		longint best [NODES];
		bit     reach [NODES];
		bit     changed;
		int     n;
		longint nd;
		route_t r;
		n = live_nodes();
		r.span = '0;
		r.flags = {dropped, 1'b0};
		if (s >= n || d >= n)
			return r;
		foreach (reach[i]) begin
			reach[i] = 0;
			best[i] = 0;
		end
		reach[s] = 1;
		do begin
			changed = 0;
			for (int i = 0; i < e_fill; i++) begin
				if (e_src[i] < n && e_dst[i] < n && reach[e_src[i]]) begin
					nd = best[e_src[i]] + longint'(e_wgt[i]);
					if (!reach[e_dst[i]] || nd < best[e_dst[i]]) begin
						reach[e_dst[i]] = 1;
						best[e_dst[i]] = nd;
						changed = 1;
					end
				end
			end
		end while (changed);
		if (reach[d]) begin
			r.span = (best[d] > spe_pkg::DIST_MAX) ? {6'd0, spe_pkg::DIST_MAX} :
				32'(best[d]);
			r.flags[0] = 1'b1;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		route_t exp_r;
		int n;
		if (!arst_n) begin
			node_count = 9'd256;
			e_fill = 0;
			dropped = 0;
			fails = 0;
			results = 0;
			routes_due.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				results++;
				if (routes_due.size() == 0) begin
					fails++;
					$display("%0t: unexpected result data=%h user=%b", $time, m_tdata, m_tuser);
				end else begin
					exp_r = routes_due.pop_front();
					if (m_tdata !== exp_r.span || m_tuser !== exp_r.flags) begin
						fails++;
						$display("%0t: mismatch expected data=%h user=%b actual data=%h user=%b",
							$time, exp_r.span, exp_r.flags, m_tdata, m_tuser);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				n = live_nodes();
				case (s_tuser)
					spe_pkg::CMD_ADD: begin
						if (e_fill >= EDGES || int'(s_tdata[7:0]) >= n ||
								int'(s_tdata[15:8]) >= n) begin
							dropped = 1;
						end else begin
							e_src[e_fill] = s_tdata[7:0];
							e_dst[e_fill] = s_tdata[15:8];
							e_wgt[e_fill] = s_tdata[31:16];
							e_fill++;
						end
					end
					spe_pkg::CMD_QUERY: routes_due = {routes_due,
						solve_route(int'(s_tdata[39:32]), int'(s_tdata[47:40]))};
					spe_pkg::CMD_CLEAR: begin
						e_fill = 0;
						dropped = 0;
					end
					default: ;
				endcase
			end
			if (cfg_valid && cfg_ready)
				node_count = cfg_data;
		end
		pending = routes_due.size();
	end
endmodule

[test/tb_shortest_path_engine.sv]
module tb_shortest_path_engine;

	localparam logic [1:0] CMD_NONE = 2'd3;
	localparam longint CYCLE_LIMIT = 60000000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [8:0]  cfg_data = '0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;
	int          fails, pending, results;
	int          tx_idle = 0, rx_idle = 0;
	int          hold_req = 0;
	int          sent = 0, cfg_writes = 0;
	longint      cycles = 0;

	shortest_path_engine uut (.*);

	shortest_path_checker chk (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_shortest_path_engine NOT OK");
			$finish;
		end
	end

	always @(negedge clk) begin
		static int hold_seen = 0;
		static int hold_left = 0;
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = 20000;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle);
		end
	end

	task automatic put_item(input logic [1:0] c, input logic [7:0] es, input logic [7:0] et,
			input logic [15:0] w, input logic [7:0] qs, input logic [7:0] qt);
		while ($urandom_range(99) < tx_idle) begin
			s_tvalid <= 0;
			@(negedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= c;
		s_tdata <= {qt, qs, w, et, es};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		sent++;
	endtask

	task automatic add_edge(input int es, input int et, input int w);
		put_item(spe_pkg::CMD_ADD, 8'(es), 8'(et), 16'(w), 8'($urandom), 8'($urandom));
	endtask

	task automatic ask_route(input int qs, input int qt);
		put_item(spe_pkg::CMD_QUERY, 8'($urandom), 8'($urandom), 16'($urandom), 8'(qs),
			8'(qt));
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (pending != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic set_nodes(input int n);
		drain();
		cfg_valid <= 1;
		cfg_data <= 9'(n);
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 0;
		cfg_writes++;
	endtask

	function automatic int pick_node(input int n);
		int lim;
		lim = (n > 256) ? 256 : n;
		if (lim == 0 || $urandom_range(99) < 6)
			return $urandom_range(255);
		if ($urandom_range(99) < 70 && lim > 10)
			return $urandom_range(9);
		return $urandom_range(lim - 1);
	endfunction

	function automatic int pick_weight();
		case ($urandom_range(5))
			0: return 0;
			1: return 16'hFFFF;
			2: return $urandom_range(15);
			default: return $urandom_range(16'hFFFF);
		endcase
	endfunction

	task automatic run_phase(input int count);
		int done;
		int n;
		int ne;
		done = 0;
		n = 256;
		while (done < count) begin
			case ($urandom_range(10))
				0: n = 0;
				1: n = 1;
				2: n = 2;
				3: n = 256;
				4: n = 511;
				5: n = 3;
				6: n = 8;
				7: n = 16;
				default: n = $urandom_range(1, 256);
			endcase
			set_nodes(n);
			if ($urandom_range(3) != 0) begin
				put_item(spe_pkg::CMD_CLEAR, 8'($urandom), 8'($urandom), 16'($urandom),
					8'($urandom), 8'($urandom));
				done++;
			end
			ne = $urandom_range(2, 14);
			for (int k = 0; k < ne; k++) begin
				add_edge(pick_node(n), pick_node(n), pick_weight());
				done++;
				if ($urandom_range(99) < 25) begin
					ask_route(pick_node(n), pick_node(n));
					done++;
				end
				if ($urandom_range(99) < 3)
					put_item(CMD_NONE, 8'($urandom), 8'($urandom), 16'($urandom),
						8'($urandom), 8'($urandom));
			end
			repeat (3) begin
				ask_route(pick_node(n), pick_node(n));
				done++;
			end
		end
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		ask_route(0, 0);
		ask_route(0, 1);
		add_edge(0, 1, 16'hFFFF);
		add_edge(1, 255, 0);
		add_edge(255, 0, 1);
		put_item(CMD_NONE, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF);
		ask_route(0, 255);
		ask_route(255, 1);
		set_nodes(4);
		add_edge(5, 0, 3);
		add_edge(0, 9, 3);
		ask_route(0, 1);
		ask_route(0, 7);
		ask_route(200, 1);
		put_item(spe_pkg::CMD_CLEAR, '0, '0, '0, '0, '0);
		ask_route(1, 1);
		set_nodes(0);
		ask_route(0, 0);
		set_nodes(511);
		ask_route(255, 0);

		set_nodes(1);
		put_item(spe_pkg::CMD_CLEAR, '0, '0, '0, '0, '0);
		for (int k = 0; k < 1025; k++)
			add_edge(0, 0, pick_weight());
		ask_route(0, 0);
		put_item(spe_pkg::CMD_CLEAR, '0, '0, '0, '0, '0);

		tx_idle = 23;
		rx_idle = 62;
		run_phase(50);
		tx_idle = 62;
		rx_idle = 23;
		set_nodes(8);
		hold_req++;
		repeat (8) ask_route($urandom_range(7), $urandom_range(7));
		run_phase(50);
		tx_idle = 0;
		rx_idle = 0;
		run_phase(50);

		drain();
		$display("run covered %0d items, %0d results checked, %0d node-count writes",
			sent, results, cfg_writes);
		if (fails == 0)
			$display("tb_shortest_path_engine OK");
		else
			$display("tb_shortest_path_engine NOT OK");
		$finish;
	end
endmodule

[shortest_path_engine.f]
+incdir+rtl
rtl/spe_pkg.sv
rtl/spe_ram.sv
rtl/spe_ctrl.sv
rtl/spe_datapath.sv
rtl/shortest_path_engine.sv
test/shortest_path_checker.sv
test/tb_shortest_path_engine.sv
